### rtl/cba_pkg.sv
// Package of shared widths and codes for the contiguous block allocator.
`default_nettype none

package cba_pkg;

  // Busy-map word handled by the scanner in one cycle.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 5;

  // Item field widths.
  localparam int unsigned START_W = 10;
  localparam int unsigned CNT_W   = 11;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  // Request kinds carried in the input tuser bit.
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

endpackage : cba_pkg

`default_nettype wire

### rtl/contiguous_block_allocator.sv
// First-fit contiguous block allocator over a word-organised busy map.
// Allocate scans the map word by word, then runs a set-up step and a read-modify-write pass
// over the words of the run before the result; release skips the scan.
// NUM_WORDS = ceil(NUM_BLOCKS / 32).
// One item is in flight at a time; the next is taken in the cycle after its result leaves.
// Reset clears the control state; a clearing pass then zeroes the map.
`default_nettype none

module contiguous_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // start_block [9:0], block_count [20:10], zero padding [23:21]
  input  wire logic [cba_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // kind [0]
  input  wire logic                             s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // run_start [9:0], zero padding [15:10]
  output logic [cba_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o,
  // ok [0]
  output logic                                  m_axis_tuser_o
);

  localparam int unsigned WORD_W    = cba_pkg::WORD_W;
  localparam int unsigned IDX_W     = cba_pkg::IDX_W;
  localparam int unsigned START_W   = cba_pkg::START_W;
  localparam int unsigned CNT_W     = cba_pkg::CNT_W;
  localparam int unsigned NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned WC_W      = $clog2(NUM_WORDS + 1);
  localparam int unsigned RUN_W     = $clog2(NUM_WORDS * WORD_W + 1);
  localparam int unsigned EXT_W     = ((RUN_W > CNT_W) ? RUN_W : CNT_W) + 1;
  localparam logic [EXT_W-1:0] NB_EXT   = EXT_W'(NUM_BLOCKS);
  localparam logic [WA_W-1:0]  LAST_WRD = WA_W'(NUM_WORDS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_MSET  = 3'd3;
  localparam logic [2:0] ST_MARK  = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [WC_W-1:0]    iss_q, iss_d;
  logic               pend_q, pend_d;
  logic [WA_W-1:0]    proc_q, proc_d;
  logic [WA_W-1:0]    last_q, last_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic               kind_q, kind_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [EXT_W-1:0]   lo_q, lo_d;
  logic [EXT_W-1:0]   hi_q, hi_d;
  logic               ok_q, ok_d;
  logic [START_W-1:0] rs_q, rs_d;

  logic [WORD_W-1:0]  mem [NUM_WORDS];
  logic [WORD_W-1:0]  rd_q;
  logic               rd_en;
  logic [WA_W-1:0]    rd_addr;
  logic               wr_en;
  logic [WA_W-1:0]    wr_addr;
  logic [WORD_W-1:0]  wr_data;

  logic               s_acc;
  logic               m_acc;
  logic [START_W-1:0] in_start;
  logic [CNT_W-1:0]   in_count;
  logic [EXT_W-1:0]   rel_sum;

  logic [WORD_W-1:0]  free_w;
  logic [WORD_W-1:0]  hit_w;
  logic [WORD_W-1:0]  mark_w;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   lead;
  logic               found;
  logic [RUN_W-1:0]   run_nxt;
  logic [EXT_W-1:0]   hit_end;
  logic [EXT_W-1:0]   hit_lo;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc    = m_axis_tvalid_o && m_axis_tready_i;
  assign in_start = s_axis_tdata_i[START_W-1:0];
  assign in_count = s_axis_tdata_i[START_W +: CNT_W];
  assign rel_sum  = EXT_W'(in_start) + EXT_W'(in_count);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_RESP);
  assign m_axis_tdata_o  = {{(cba_pkg::OUT_DATA_W - START_W){1'b0}}, rs_q};
  assign m_axis_tuser_o  = ok_q;

  // Scanner: examines the word in rd_q, carrying the free run that ends at its bottom.
  always_comb begin
    logic [EXT_W-1:0] blk;
    logic             pre;
    logic             win_ok;
    free_w = '0;
    hit_w  = '0;
    mark_w = '0;
    pre    = 1'b1;
    blk    = '0;
    win_ok = 1'b1;
    for (int j = 0; j < WORD_W; j++) begin
      blk       = EXT_W'({proc_q, IDX_W'(j)});
      free_w[j] = !rd_q[j] && (blk < NB_EXT);
      mark_w[j] = (blk >= lo_q) && (blk < hi_q);
    end
    for (int i = 0; i < WORD_W; i++) begin
      pre = pre && free_w[i];
      if (count_q > CNT_W'(i + 1)) begin
        // A run this long must also use the free blocks carried from earlier words.
        hit_w[i] = pre && (EXT_W'(run_q) + EXT_W'(i + 1) >= EXT_W'(count_q));
      end else begin
        win_ok = 1'b1;
        for (int j = 0; j <= i; j++) begin
          if (count_q > CNT_W'(i - j)) begin
            win_ok = win_ok && free_w[j];
          end
        end
        hit_w[i] = win_ok;
      end
    end
    hit_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit_w[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
    lead = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!free_w[i]) begin
        lead = IDX_W'(WORD_W - 1 - i);
      end
    end
    found   = |hit_w;
    run_nxt = (&free_w) ? run_q + RUN_W'(WORD_W) : RUN_W'(lead);
    hit_end = EXT_W'({proc_q, hit_idx}) + EXT_W'(1);
    hit_lo  = hit_end - EXT_W'(count_q);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    pend_d  = 1'b0;
    proc_d  = proc_q;
    last_d  = last_q;
    run_d   = run_q;
    kind_d  = kind_q;
    count_d = count_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    ok_d    = ok_q;
    rs_d    = rs_q;
    rd_en   = 1'b0;
    rd_addr = iss_q[WA_W-1:0];
    wr_en   = 1'b0;
    wr_addr = iss_q[WA_W-1:0];
    wr_data = '0;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (iss_q[WA_W-1:0] == LAST_WRD) begin
          iss_d   = '0;
          state_d = ST_IDLE;
        end else begin
          iss_d = iss_q + WC_W'(1);
        end
      end
      ST_IDLE: begin
        if (s_acc) begin
          kind_d  = s_axis_tuser_i;
          count_d = in_count;
          if (s_axis_tuser_i == cba_pkg::KIND_RELEASE) begin
            ok_d    = 1'b1;
            rs_d    = in_start;
            lo_d    = EXT_W'(in_start);
            hi_d    = (rel_sum > NB_EXT) ? NB_EXT : rel_sum;
            state_d = ((in_count == '0) || (EXT_W'(in_start) >= NB_EXT)) ? ST_RESP : ST_MSET;
          end else if (in_count == '0) begin
            ok_d    = 1'b1;
            rs_d    = '0;
            state_d = ST_RESP;
          end else if (EXT_W'(in_count) > NB_EXT) begin
            ok_d    = 1'b0;
            rs_d    = '0;
            state_d = ST_RESP;
          end else begin
            iss_d   = '0;
            run_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (iss_q < WC_W'(NUM_WORDS)) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          proc_d = iss_q[WA_W-1:0];
          iss_d  = iss_q + WC_W'(1);
        end
        if (pend_q) begin
          if (found) begin
            lo_d    = hit_lo;
            hi_d    = hit_end;
            ok_d    = 1'b1;
            rs_d    = hit_lo[START_W-1:0];
            pend_d  = 1'b0;
            state_d = ST_MSET;
          end else if (proc_q == LAST_WRD) begin
            ok_d    = 1'b0;
            rs_d    = '0;
            pend_d  = 1'b0;
            state_d = ST_RESP;
          end else begin
            run_d = run_nxt;
          end
        end
      end
      ST_MSET: begin
        iss_d   = WC_W'(lo_q >> IDX_W);
        last_d  = WA_W'((hi_q - EXT_W'(1)) >> IDX_W);
        state_d = ST_MARK;
      end
      ST_MARK: begin
        // Read of the next word overlaps the write-back of the previous one.
        if (iss_q <= WC_W'(last_q)) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          proc_d = iss_q[WA_W-1:0];
          iss_d  = iss_q + WC_W'(1);
        end
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = proc_q;
          wr_data = (kind_q == cba_pkg::KIND_ALLOC) ? (rd_q | mark_w) : (rd_q & ~mark_w);
          if (proc_q == last_q) begin
            pend_d  = 1'b0;
            state_d = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (m_acc) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      iss_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_q  <= proc_d;
    last_q  <= last_d;
    run_q   <= run_d;
    kind_q  <= kind_d;
    count_q <= count_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    ok_q    <= ok_d;
    rs_q    <= rs_d;
  end

  // Busy map memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  // Only one item is ever in flight.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input taken again straight after an item");

  a_fail_zero_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("failed allocation reports a non-zero start");

  a_mark_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MARK) && pend_q) |-> (proc_q <= last_q))
    else $error("write-back beyond the last word of the run");
`endif

endmodule : contiguous_block_allocator

`default_nettype wire
